// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Both macros expect signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define WDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define WDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/wdf_pkg.sv =====
// Shared constants and types for the wedge dissipation function pipeline.
// No dependencies.
package wdf_pkg;

  localparam int FRAC = 58;
  localparam logic signed [63:0] PI_Q      = 64'sh0C90FDAA22168C23;
  localparam logic signed [63:0] HALF_PI_Q = 64'sh06487ED5110B4611;
  localparam logic signed [63:0] ONE_Q     = 64'sh0400000000000000;
  localparam logic [63:0] RESULT_LIMIT     = 64'd167772160000000000;
  localparam logic [31:0] MU_RESET         = 32'h0001_0000;

  // divider: 128 numerator bits plus 9 extra quotient bits
  localparam int DIV_STEPS = 137;
  localparam int DD_W      = 98;
  localparam int QUO_W     = 58;
  localparam logic [DD_W-1:0] SING_THRESH = DD_W'(65536);

  // series cell pipeline: product, reciprocal product, correction, accumulate
  localparam int CELL_LAT = 7;

  typedef logic signed [63:0] fix_t;

  typedef struct packed {
    fix_t s_term;
    fix_t s_acc;
    fix_t c_term;
    fix_t c_acc;
    fix_t x2;
    fix_t t;
    fix_t pm;
  } sc_state_t;

  typedef struct packed {
    logic [127:0]      num;
    logic [DD_W-1:0]   dd;
    logic [DD_W-1:0]   rem;
    logic [QUO_W-1:0]  quo;
    logic              over;
    logic              pos;
    logic              dneg;
  } div_state_t;

endpackage

// ===== src/wdf_umul.sv =====
// Two-stage unsigned multiplier built from registered 32x32 partial products.
// Depends on nothing.
module wdf_umul #(
  parameter int AW = 64,
  parameter int BW = 64
) (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic [AW+BW-1:0] p
);
  localparam int NA  = (AW + 31) / 32;
  localparam int NB  = (BW + 31) / 32;
  localparam int AXW = 32 * NA;
  localparam int BXW = 32 * NB;
  localparam int PW  = AXW + BXW;

  logic [AXW-1:0] a_ext;
  logic [BXW-1:0] b_ext;
  logic [63:0]    pp [NA*NB];
  logic [PW-1:0]  sum;

  assign a_ext = AXW'(a);
  assign b_ext = BXW'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i*NB+j] <= a_ext[32*i +: 32] * b_ext[32*j +: 32];
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (PW'(pp[i*NB+j]) << (32*(i+j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum[AW+BW-1:0];
    end
  end

endmodule

// ===== src/wdf_qmul.sv =====
// Q5.58 signed product, truncated toward zero, saturating; registered output.
// Depends on wdf_pkg and wdf_umul.
module wdf_qmul import wdf_pkg::*; (
  input  logic clk,
  input  logic en,
  input  fix_t a,
  input  fix_t b,
  output fix_t p
);
  logic [63:0]  ma, mb;
  logic [127:0] prod;
  logic         neg1, neg2;
  logic [62:0]  mag;
  logic [63:0]  mag_ext;

  assign ma = a[63] ? 64'(-a) : 64'(a);
  assign mb = b[63] ? 64'(-b) : 64'(b);

  wdf_umul #(.AW(64), .BW(64)) u_mul (
    .clk (clk),
    .en  (en),
    .a   (ma),
    .b   (mb),
    .p   (prod)
  );

  assign mag = (prod[127:FRAC+63] != '0) ? {63{1'b1}} : prod[FRAC+62:FRAC];
  assign mag_ext = {1'b0, mag};

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[63] ^ b[63];
      neg2 <= neg1;
      p    <= neg2 ? (64'd0 - mag_ext) : mag_ext;
    end
  end

endmodule

// ===== src/wdf_delay.sv =====
// Enable-gated shift line that keeps side data aligned with a pipeline.
// Depends on nothing.
module wdf_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

// ===== src/wdf_sc_lane.sv =====
// One Taylor term step: term' = -(term * x2) / DIVISOR, acc' = acc + term'.
// Division by the constant uses a reciprocal product and one correction.
// Depends on wdf_pkg, wdf_qmul, wdf_umul and wdf_delay.
module wdf_sc_lane import wdf_pkg::*; #(
  parameter int DIVISOR = 2
) (
  input  logic clk,
  input  logic en,
  input  fix_t term_in,
  input  fix_t acc_in,
  input  fix_t x2,
  output fix_t term_out,
  output fix_t acc_out
);
  localparam logic [63:0] DIV64 = 64'(DIVISOR);
  localparam logic [63:0] RECIP = 64'h8000_0000_0000_0000 / DIV64;

  fix_t         prod;
  logic [63:0]  pmag;
  logic [127:0] rprod;
  logic [63:0]  mag_a, mag_b;
  logic         neg_a, neg_b;
  logic [63:0]  qest, rem;
  logic [63:0]  quo;
  logic         flip;
  fix_t         acc_d;

  wdf_qmul u_mul (
    .clk (clk),
    .en  (en),
    .a   (term_in),
    .b   (x2),
    .p   (prod)
  );

  assign pmag = prod[63] ? 64'(-prod) : 64'(prod);

  wdf_umul #(.AW(64), .BW(64)) u_rcp (
    .clk (clk),
    .en  (en),
    .a   (pmag),
    .b   (RECIP),
    .p   (rprod)
  );

  wdf_delay #(.W(64), .N(CELL_LAT-1)) u_acc (
    .clk (clk),
    .en  (en),
    .d   (acc_in),
    .q   (acc_d)
  );

  // estimate is floor(n/D) or one less
  assign qest = rprod[126:63];
  assign rem  = mag_b - qest * DIV64;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a    <= pmag;
      neg_a    <= prod[63];
      mag_b    <= mag_a;
      neg_b    <= neg_a;
      quo      <= (rem >= DIV64) ? qest + 64'd1 : qest;
      flip     <= !neg_b;
      term_out <= flip ? (64'd0 - quo) : quo;
      acc_out  <= flip ? (acc_d - fix_t'(quo)) : (acc_d + fix_t'(quo));
    end
  end

endmodule

// ===== src/wdf_sc_cell.sv =====
// Series cell K: advances the sine and cosine expansions by one term.
// Depends on wdf_pkg, wdf_sc_lane and wdf_delay.
module wdf_sc_cell import wdf_pkg::*; #(
  parameter int K = 1
) (
  input  logic      clk,
  input  logic      en,
  input  sc_state_t d,
  output sc_state_t q
);
  localparam int SIN_DIV = (2*K - 1) * (2*K);
  localparam int COS_DIV = (2*K) * (2*K + 1);

  fix_t s_term, s_acc, c_term, c_acc, x2_d, t_d, pm_d;

  wdf_sc_lane #(.DIVISOR(SIN_DIV)) u_cos_x (
    .clk      (clk),
    .en       (en),
    .term_in  (d.s_term),
    .acc_in   (d.s_acc),
    .x2       (d.x2),
    .term_out (s_term),
    .acc_out  (s_acc)
  );

  wdf_sc_lane #(.DIVISOR(COS_DIV)) u_sin_x (
    .clk      (clk),
    .en       (en),
    .term_in  (d.c_term),
    .acc_in   (d.c_acc),
    .x2       (d.x2),
    .term_out (c_term),
    .acc_out  (c_acc)
  );

  wdf_delay #(.W(192), .N(CELL_LAT)) u_side (
    .clk (clk),
    .en  (en),
    .d   ({d.x2, d.t, d.pm}),
    .q   ({x2_d, t_d, pm_d})
  );

  always_comb begin
    q = '{s_term: s_term, s_acc: s_acc, c_term: c_term, c_acc: c_acc,
          x2: x2_d, t: t_d, pm: pm_d};
  end

endmodule

// ===== src/wdf_div_cell.sv =====
// One restoring-division step with a sticky overflow of the quotient.
// Depends on wdf_pkg.
module wdf_div_cell import wdf_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  div_state_t d,
  output div_state_t q
);
  logic [DD_W:0]  rem_sh;
  logic [DD_W:0]  dd_ext;
  logic           ge;
  logic [QUO_W:0] qn;

  assign rem_sh = {d.rem, d.num[127]};
  assign dd_ext = {1'b0, d.dd};
  assign ge     = rem_sh >= dd_ext;
  assign qn     = {d.quo, ge};

  always_ff @(posedge clk) begin
    if (en) begin
      q.num  <= {d.num[126:0], 1'b0};
      q.dd   <= d.dd;
      q.rem  <= ge ? DD_W'(rem_sh - dd_ext) : rem_sh[DD_W-1:0];
      q.quo  <= qn[QUO_W-1:0];
      q.over <= d.over | (qn > (QUO_W+1)'(RESULT_LIMIT));
      q.pos  <= d.pos;
      q.dneg <= d.dneg;
    end
  end

endmodule

// ===== src/wedge_dissipation_function_top.sv =====
// Wedge-flow dissipation function f(theta, mu_r): input clamp, series cells,
// product stages and divider chain. Depends on wdf_pkg and all wdf_ modules.
//
// Usage:
//   Input channel in_valid/in_ready carries contact_angle (unsigned, angle
//   fraction bits set by ANGLE_FRAC_BITS). Output channel out_valid/out_ready
//   carries dissipation_value (signed Q40.24, saturated to +/-1e10) and
//   singular. cfg_write/cfg_data load viscosity_ratio (Q16.16); the user must
//   load it only while no item is in flight, which the block does not enforce.
//   From the accepting edge to out_valid an item passes the clamp and x^2,
//   the series cells, the product stages, 137 divider cells and then the
//   output register. One item is accepted every cycle while in_ready is high.
//   Reset clears all valid bits, out_valid included, and sets the
//   viscosity ratio to 1.0.
//   When the receiver stalls, the finished item waits in the output register
//   and the pipeline keeps moving until an item reaches the last divider
//   cell; only then does the whole pipeline hold and in_ready drop.
`include "assert_macros.svh"

module wedge_dissipation_function_top import wdf_pkg::*; #(
  parameter int ANGLE_FRAC_BITS   = 30,
  parameter int SINCOS_ITERATIONS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        contact_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] dissipation_value,
  output logic               singular,
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data
);
  localparam int ANGLE_SHIFT = FRAC - ANGLE_FRAC_BITS;
  localparam logic [63:0] PI_RAW    = 64'(PI_Q) >> ANGLE_SHIFT;
  localparam logic [31:0] ANGLE_MAX = 32'(PI_RAW - 64'd1);
  localparam int PRE_LAT  = 4;
  localparam int POST_LAT = 19;
  localparam int LAT = PRE_LAT + CELL_LAT * SINCOS_ITERATIONS + POST_LAT + DIV_STEPS;
  localparam logic signed [63:0] LIMIT_POS = RESULT_LIMIT;
  localparam logic signed [63:0] LIMIT_NEG = 64'd0 - RESULT_LIMIT;

  logic [31:0]  viscosity_ratio;
  logic [LAT-1:0] vld;
  logic         adv;

  // input stage
  logic [31:0]  angle_clamped;
  logic [63:0]  t_comb;
  fix_t         s0_t, s0_pm, s0_x;
  fix_t         x2, x_d, t_d, pm_d;

  sc_state_t    sc [SINCOS_ITERATIONS+1];
  fix_t         sv, cv, tv, pmv;

  // trig products and f terms
  fix_t         s2, scn, tt, pp, tp, s_p, t_p, pm_p;
  fix_t         f1, f1p, f2, f2p, f3, c_s2, c_s;
  fix_t         s3, dq, eq, f1_d, f1p_d, f3_d;
  fix_t         aq, bq, cq, dq_d, eq_d;

  // wide products
  logic [63:0]  mag_a, mag_b, mag_d;
  logic         neg_a, neg_b, neg_d;
  fix_t         cq_r, eq_r;
  logic [95:0]  amu, bmu, dmu, bmu_d, dmu_d;
  logic         neg_a1, neg_b1, neg_d1, neg_a2, neg_b2, neg_d2;
  fix_t         cq1, eq1, cq2, eq2;
  logic [127:0] amu2;
  logic [127:0] bsh, dext;
  logic [127:0] ta, tb, tc, td, te;
  logic [127:0] num, den;
  logic [127:0] abs_num;
  logic [96:0]  abs_den;
  logic         pos3, dneg3;

  div_state_t   dv [DIV_STEPS+1];
  div_state_t   dfin;
  logic         sing;
  logic [63:0]  qf;
  logic signed [63:0] res;

  assign adv      = !(vld[LAT-1] && out_valid && !out_ready);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      viscosity_ratio <= MU_RESET;
    end else if (cfg_write) begin
      viscosity_ratio <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_comb begin
    angle_clamped = contact_angle;
    if (contact_angle < 32'd1) begin
      angle_clamped = 32'd1;
    end else if (contact_angle > ANGLE_MAX) begin
      angle_clamped = ANGLE_MAX;
    end
  end

  assign t_comb = 64'(angle_clamped) << ANGLE_SHIFT;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_t  <= t_comb;
      s0_pm <= PI_Q - fix_t'(t_comb);
      s0_x  <= fix_t'(t_comb) - HALF_PI_Q;
    end
  end

  wdf_qmul u_x2 (.clk(clk), .en(adv), .a(s0_x), .b(s0_x), .p(x2));

  wdf_delay #(.W(192), .N(3)) u_d_x (
    .clk (clk), .en(adv), .d({s0_x, s0_t, s0_pm}), .q({x_d, t_d, pm_d})
  );

  // series start: cos(x) from 1, sin(x) from x
  always_comb begin
    sc[0] = '{s_term: ONE_Q, s_acc: ONE_Q, c_term: x_d, c_acc: x_d,
              x2: x2, t: t_d, pm: pm_d};
  end

  for (genvar k = 0; k < SINCOS_ITERATIONS; k++) begin : g_cell
    wdf_sc_cell #(.K(k + 1)) u_cell (
      .clk (clk), .en(adv), .d(sc[k]), .q(sc[k+1])
    );
  end

  assign sv  = sc[SINCOS_ITERATIONS].s_acc;
  assign cv  = sc[SINCOS_ITERATIONS].c_acc;   // cos(theta) = -cv
  assign tv  = sc[SINCOS_ITERATIONS].t;
  assign pmv = sc[SINCOS_ITERATIONS].pm;

  wdf_qmul u_s2 (.clk(clk), .en(adv), .a(sv), .b(sv), .p(s2));
  wdf_qmul u_sc (.clk(clk), .en(adv), .a(sv), .b(cv), .p(scn));
  wdf_qmul u_tt (.clk(clk), .en(adv), .a(tv), .b(tv), .p(tt));
  wdf_qmul u_pp (.clk(clk), .en(adv), .a(pmv), .b(pmv), .p(pp));
  wdf_qmul u_tp (.clk(clk), .en(adv), .a(tv), .b(pmv), .p(tp));

  wdf_delay #(.W(192), .N(3)) u_d_p1 (
    .clk (clk), .en(adv), .d({sv, tv, pmv}), .q({s_p, t_p, pm_p})
  );

  // scn is -sin*cos
  always_ff @(posedge clk) begin
    if (adv) begin
      f1   <= tt - s2;
      f1p  <= pp - s2;
      f2   <= t_p + scn;
      f2p  <= pm_p - scn;
      f3   <= tp + s2;
      c_s2 <= s2;
      c_s  <= s_p;
    end
  end

  wdf_qmul u_s3 (.clk(clk), .en(adv), .a(c_s2), .b(c_s), .p(s3));
  wdf_qmul u_dq (.clk(clk), .en(adv), .a(f1), .b(f2p), .p(dq));
  wdf_qmul u_eq (.clk(clk), .en(adv), .a(f1p), .b(f2), .p(eq));

  wdf_delay #(.W(192), .N(3)) u_d_p2 (
    .clk (clk), .en(adv), .d({f1, f1p, f3}), .q({f1_d, f1p_d, f3_d})
  );

  wdf_qmul u_aq (.clk(clk), .en(adv), .a(s3), .b(f1_d), .p(aq));
  wdf_qmul u_bq (.clk(clk), .en(adv), .a(s3), .b(f3_d), .p(bq));
  wdf_qmul u_cq (.clk(clk), .en(adv), .a(s3), .b(f1p_d), .p(cq));

  wdf_delay #(.W(128), .N(3)) u_d_p3 (
    .clk (clk), .en(adv), .d({dq, eq}), .q({dq_d, eq_d})
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_a <= aq[63] ? 64'(-aq) : 64'(aq);
      mag_b <= bq[63] ? 64'(-bq) : 64'(bq);
      mag_d <= dq_d[63] ? 64'(-dq_d) : 64'(dq_d);
      neg_a <= aq[63];
      neg_b <= bq[63];
      neg_d <= dq_d[63];
      cq_r  <= cq;
      eq_r  <= eq_d;
    end
  end

  wdf_umul #(.AW(64), .BW(32)) u_amu (
    .clk(clk), .en(adv), .a(mag_a), .b(viscosity_ratio), .p(amu)
  );
  wdf_umul #(.AW(64), .BW(32)) u_bmu (
    .clk(clk), .en(adv), .a(mag_b), .b(viscosity_ratio), .p(bmu)
  );
  wdf_umul #(.AW(64), .BW(32)) u_dmu (
    .clk(clk), .en(adv), .a(mag_d), .b(viscosity_ratio), .p(dmu)
  );

  wdf_delay #(.W(131), .N(2)) u_d_m1 (
    .clk (clk), .en(adv),
    .d   ({neg_a, neg_b, neg_d, cq_r, eq_r}),
    .q   ({neg_a1, neg_b1, neg_d1, cq1, eq1})
  );

  wdf_umul #(.AW(96), .BW(32)) u_amu2 (
    .clk(clk), .en(adv), .a(amu), .b(viscosity_ratio), .p(amu2)
  );

  wdf_delay #(.W(323), .N(2)) u_d_m2 (
    .clk (clk), .en(adv),
    .d   ({bmu, dmu, neg_a1, neg_b1, neg_d1, cq1, eq1}),
    .q   ({bmu_d, dmu_d, neg_a2, neg_b2, neg_d2, cq2, eq2})
  );

  assign bsh  = {15'd0, bmu_d, 17'd0};
  assign dext = {32'd0, dmu_d};

  always_ff @(posedge clk) begin
    if (adv) begin
      ta <= neg_a2 ? (128'd0 - amu2) : amu2;
      tb <= neg_b2 ? (128'd0 - bsh) : bsh;
      tc <= {{32{cq2[63]}}, cq2, 32'd0};
      td <= neg_d2 ? (128'd0 - dext) : dext;
      te <= {{48{eq2[63]}}, eq2, 16'd0};
    end
  end

  // sums wrap at 128 bits
  always_ff @(posedge clk) begin
    if (adv) begin
      num <= ta + tb + tc;
      den <= td - te;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      abs_num <= num[127] ? (128'd0 - num) : num;
      abs_den <= den[127] ? 97'(128'd0 - den) : den[96:0];
      pos3    <= !num[127] && (num != '0);
      dneg3   <= den[127];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].num  <= abs_num;
      dv[0].dd   <= DD_W'(abs_den) + DD_W'({abs_den, 1'b0});
      dv[0].rem  <= '0;
      dv[0].quo  <= '0;
      dv[0].over <= 1'b0;
      dv[0].pos  <= pos3;
      dv[0].dneg <= dneg3;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    wdf_div_cell u_div (.clk(clk), .en(adv), .d(dv[i]), .q(dv[i+1]));
  end

  assign dfin = dv[DIV_STEPS];
  assign sing = dfin.dd < SING_THRESH;
  assign qf   = dfin.over ? RESULT_LIMIT : 64'(dfin.quo);

  always_comb begin
    if (sing) begin
      res = dfin.pos ? LIMIT_POS : LIMIT_NEG;
    end else if (dfin.dneg) begin
      res = 64'd0 - qf;
    end else begin
      res = qf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      dissipation_value <= res;
      singular          <= sing;
    end
  end

  `WDF_ASSERT_NEXT(a_last_item_loaded, vld[LAT-1] && in_ready, out_valid,
                   "finished item not loaded into output register")
  `WDF_ASSERT_NEXT(a_hold_on_stall, !in_ready, $stable(vld),
                   "pipeline moved while output stalled")
  `WDF_ASSERT(a_singular_limit,
              out_valid && singular |->
                (dissipation_value == LIMIT_POS || dissipation_value == LIMIT_NEG),
              "singular result not at the limit")
  `WDF_ASSERT(a_result_range,
              out_valid |->
                (dissipation_value <= LIMIT_POS && dissipation_value >= LIMIT_NEG),
              "result outside saturation range")

endmodule

// ===== tb/sv/tb_wedge_dissipation_function_top.sv =====
// Self-checking bench for wedge_dissipation_function_top: angle items are
// checked against an in-bench fixed-point model of f(theta, mu_r).
// Depends on wdf_pkg and the wedge_dissipation_function_top RTL.
`timescale 1ns / 1ps

module tb_wedge_dissipation_function_top;
  import wdf_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 1500;
  localparam int DRAIN_CYCLES   = 450;
  localparam int PHASE_ITEMS    = 50;
  // more items than the pipeline holds, so the input stalls during the hold
  localparam int HOLD_ITEMS     = 450;

  typedef struct {
    logic signed [63:0] value;
    logic               sing;
  } dissipation_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        contact_angle = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [63:0] dissipation_value;
  logic               singular;
  logic               cfg_write = 1'b0;
  logic [31:0]        cfg_data = '0;

  logic [31:0]  mu_model;
  dissipation_t pending_q[$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  bit           quiet = 1'b0;
  bit           hold_req = 1'b0;

  always #6 clk = ~clk;

  wedge_dissipation_function_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .contact_angle(contact_angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .dissipation_value(dissipation_value), .singular(singular),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  // Q5.58 product, truncated toward zero, saturating in magnitude
  function automatic fix_t fx_mul(fix_t a, fix_t b);
    logic [63:0]  ma, mb, r;
    logic [127:0] p;
    ma = a[63] ? 64'(-a) : 64'(a);
    mb = b[63] ? 64'(-b) : 64'(b);
    p = {64'b0, ma} * {64'b0, mb};
    if (p[127:121] != '0) r = 64'h7FFF_FFFF_FFFF_FFFF;
    else r = p[121:58];
    return (a[63] ^ b[63]) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [127:0] wide_mul(fix_t a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, (a[63] ? 64'(-a) : 64'(a))} * {64'b0, b};
    return a[63] ? -p : p;
  endfunction

  function automatic dissipation_t dissipation_of(logic [31:0] angle, logic [31:0] mu_r);
    dissipation_t res;
    logic [63:0]  raw, pmax, mu, q;
    fix_t         t, pm, x, x2, term, s, c, s2, f1, f1p, f2, f2p, f3, s3, div;
    logic [127:0] num, den, dd, n, rem;
    raw = {32'b0, angle};
    pmax = (64'(PI_Q) >> (FRAC - 30)) - 1;
    mu = {32'b0, mu_r};
    if (raw < 1) raw = 1;
    if (raw > pmax) raw = pmax;
    t = $signed(raw << (FRAC - 30));
    pm = PI_Q - t;
    x = t - HALF_PI_Q;
    x2 = fx_mul(x, x);
    s = ONE_Q;
    term = ONE_Q;
    for (int k = 1; k <= 32; k++) begin
      div = (2 * k - 1) * (2 * k);
      term = -fx_mul(term, x2) / div;
      s += term;
    end
    term = x;
    c = x;
    for (int k = 1; k <= 32; k++) begin
      div = (2 * k) * (2 * k + 1);
      term = -fx_mul(term, x2) / div;
      c += term;
    end
    c = -c;
    s2 = fx_mul(s, s);
    f1 = fx_mul(t, t) - s2;
    f1p = fx_mul(pm, pm) - s2;
    f2 = t - fx_mul(s, c);
    f2p = pm + fx_mul(s, c);
    f3 = fx_mul(t, pm) + s2;
    s3 = fx_mul(s2, s);
    num = wide_mul(fx_mul(s3, f1), mu * mu) + wide_mul(fx_mul(s3, f3), mu << 17)
        + wide_mul(fx_mul(s3, f1p), 64'h1_0000_0000);
    den = wide_mul(fx_mul(f1, f2p), mu) - wide_mul(fx_mul(f1p, f2), 64'd65536);
    dd = den[127] ? -den : den;
    dd = dd + dd + dd;
    if (dd < 128'd65536) begin
      res.value = (!num[127] && num != '0) ? $signed(RESULT_LIMIT) : -$signed(RESULT_LIMIT);
      res.sing = 1'b1;
      return res;
    end
    n = num[127] ? -num : num;
    rem = '0;
    q = '0;
    for (int k = 0; k < 137; k++) begin
      rem = {rem[126:0], (k < 128) ? n[127 - k] : 1'b0};
      q = q << 1;
      if (rem >= dd) begin
        rem = rem - dd;
        q[0] = 1'b1;
      end
      if (q > RESULT_LIMIT) q = RESULT_LIMIT + 1;
    end
    if (q > RESULT_LIMIT) q = RESULT_LIMIT;
    res.value = den[127] ? -$signed(q) : $signed(q);
    res.sing = 1'b0;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_angle(logic [31:0] angle);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    contact_angle <= angle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_q.push_back(dissipation_of(angle, mu_model));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_viscosity(logic [31:0] mu_r);
    cfg_write <= 1'b1;
    cfg_data <= mu_r;
    @(posedge clk);
    cfg_write <= 1'b0;
    mu_model = mu_r;
  endtask

  function automatic logic [31:0] random_angle();
    logic [31:0] pmax;
    pmax = 32'(64'(PI_Q) >> (FRAC - 30)) - 1;
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2, 3: return $urandom_range(1, pmax);
      4:    return $urandom_range(0, 1 << $urandom_range(0, 24));
      default: return pmax - $urandom_range(0, 1 << $urandom_range(0, 24)) + 2;
    endcase
  endfunction

  // Receiver: checks results and throttles out_ready
  initial begin
    dissipation_t want;
    int stall;
    int hold;
    stall = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: value %0d singular %0b", dissipation_value, singular);
        end else begin
          want = pending_q.pop_front();
          if (want.value !== dissipation_value || want.sing !== singular) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d/%0b got %0d/%0b",
                       want.value, want.sing, dissipation_value, singular);
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < 30)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3);
      end
    end
  end

  // Watchdog: cycles with no item accepted on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_wedge_dissipation_function_top: errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] edge_angles[] = '{
      32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0100,
      32'hC90F_DAA1, 32'hC90F_DAA2, 32'hC90F_DAA3, 32'hC90F_DAA4,
      32'hFFFF_FFFF, 32'h8000_0000, 32'h6487_ED51, 32'h6487_ED52,
      32'h4000_0000, 32'h2000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
      32'h0001_0000, 32'hC8FF_FFFF, 32'h9000_0000, 32'h1234_5678
    };
    logic [31:0] mu_steps[] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_8000,
      32'h0003_0000, 32'h0100_0000, 32'h0001_0000, 32'h0000_0000
    };
    mu_model = MU_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // edge angles at reset viscosity, then at zero and full-scale mu
    for (int m = 0; m < 3; m++) begin
      if (m == 1) write_viscosity(32'h0000_0000);
      if (m == 2) write_viscosity(32'hFFFF_FFFF);
      foreach (edge_angles[i]) send_angle(edge_angles[i]);
      wait_drained();
    end

    for (int ph = 0; ph < mu_steps.size(); ph++) begin
      write_viscosity((ph == mu_steps.size() - 1) ? $urandom() : mu_steps[ph]);
      quiet = (ph % 3 == 2);
      if (ph == 2) hold_req = 1'b1;
      for (int i = 0; i < ((ph == 2) ? HOLD_ITEMS : PHASE_ITEMS); i++)
        send_angle(random_angle());
      wait_drained();
    end

    quiet = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb_wedge_dissipation_function_top: clean");
    else
      $display("tb_wedge_dissipation_function_top: errors");
    $finish;
  end

endmodule
